// ===== src/cache_set_lru_writeback_top_defines.svh =====
// Assertion macros for the checker file of the cache set block.
`ifndef CACHE_SET_LRU_WRITEBACK_TOP_DEFINES_SVH
`define CACHE_SET_LRU_WRITEBACK_TOP_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define CSLW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define CSLW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cslw_pkg.sv =====
// Types and constants shared by the cache set block.
`timescale 1ns / 1ps

package cslw_pkg;

   localparam int TAG_BITS = 20;
   localparam int WAYS_DEFAULT = 4;

   localparam logic OP_READ = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] OUTCOME_HIT = 2'd0;
   localparam logic [1:0] OUTCOME_MISS_CLEAN = 2'd1;
   localparam logic [1:0] OUTCOME_MISS_DIRTY = 2'd2;
   localparam logic [1:0] OUTCOME_UNUSED = 2'd3;

   typedef struct packed {
      logic operation;
      logic [TAG_BITS-1:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic [2:0] dirty_count;
   } rsp_type;

endpackage

// ===== src/cslw_lookup.sv =====
// Tag lookup, victim choice and next-state logic for one access to the set.
`timescale 1ns / 1ps

module cslw_lookup #(
   parameter int WAYS = cslw_pkg::WAYS_DEFAULT,
   parameter int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  cslw_pkg::req_type                           req,
   input  logic [WAYS-1:0][cslw_pkg::TAG_BITS-1:0]     way_tag,
   input  logic [WAYS-1:0]                             way_valid,
   input  logic [WAYS-1:0]                             way_dirty,
   input  logic [WAYS-1:0][RANK_W-1:0]                 way_rank,
   output logic [WAYS-1:0][cslw_pkg::TAG_BITS-1:0]     tag_next,
   output logic [WAYS-1:0]                             valid_next,
   output logic [WAYS-1:0]                             dirty_next,
   output logic [WAYS-1:0][RANK_W-1:0]                 rank_next,
   output cslw_pkg::rsp_type                           rsp
);

   localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W = $clog2(WAYS + 1);

   logic hit;
   logic have_free;
   logic [WIDX-1:0] hit_way;
   logic [WIDX-1:0] free_way;
   logic [WIDX-1:0] lru_way;
   logic [WIDX-1:0] sel_way;
   logic [RANK_W-1:0] old_rank;
   logic [CNT_W-1:0] count;

   always_comb begin
      hit = 1'b0;
      have_free = 1'b0;
      hit_way = '0;
      free_way = '0;
      lru_way = '0;
      for (int k = WAYS - 1; k >= 0; k--) begin
         if (way_valid[k] && (way_tag[k] == req.tag)) begin
            hit = 1'b1;
            hit_way = WIDX'(k);
         end
         if (!way_valid[k]) begin
            have_free = 1'b1;
            free_way = WIDX'(k);
         end
         if (way_rank[k] == RANK_W'(WAYS - 1)) begin
            lru_way = WIDX'(k);
         end
      end
      sel_way = hit ? hit_way : (have_free ? free_way : lru_way);
   end

   always_comb begin
      tag_next = way_tag;
      valid_next = way_valid;
      dirty_next = way_dirty;
      rank_next = way_rank;
      old_rank = way_rank[sel_way];
      for (int k = 0; k < WAYS; k++) begin
         if (way_rank[k] < old_rank) begin
            rank_next[k] = way_rank[k] + RANK_W'(1);
         end
      end
      rank_next[sel_way] = '0;
      if (hit) begin
         if (req.operation == cslw_pkg::OP_WRITE) begin
            dirty_next[sel_way] = 1'b1;
         end
      end else begin
         tag_next[sel_way] = req.tag;
         valid_next[sel_way] = 1'b1;
         dirty_next[sel_way] = (req.operation == cslw_pkg::OP_WRITE);
      end
   end

   always_comb begin
      count = '0;
      for (int k = 0; k < WAYS; k++) begin
         count = count + CNT_W'(dirty_next[k]);
      end
      if (hit) begin
         rsp.outcome = cslw_pkg::OUTCOME_HIT;
      end else if (!have_free && way_dirty[lru_way]) begin
         rsp.outcome = cslw_pkg::OUTCOME_MISS_DIRTY;
      end else begin
         rsp.outcome = cslw_pkg::OUTCOME_MISS_CLEAN;
      end
      rsp.dirty_count = 3'(count);
   end

endmodule

// ===== src/cache_set_lru_writeback_top.sv =====
// Top level of one set of a write-back cache with true LRU replacement.
//
//   Channel   Direction  Payload               Transfer when
//   req       in         operation, tag        req_valid && req_ready
//   rsp       out        outcome, dirty_count  rsp_valid && rsp_ready
//
// An access is registered on transfer and resolved once the result register is
// free or being read, updating the set state and the result register together.
// One access per cycle unless results stall; one result register sets that rate.
// A stalled result holds the access in the input register and lowers req_ready.
// Synchronous reset empties the set and gives way k the recency rank k.
`timescale 1ns / 1ps

module cache_set_lru_writeback_top #(
   parameter int WAYS = cslw_pkg::WAYS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cslw_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cslw_pkg::rsp_type  rsp_payload
);

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic in_valid_ff;
   cslw_pkg::req_type in_req_ff;
   logic rsp_valid_ff;
   cslw_pkg::rsp_type rsp_ff;
   cslw_pkg::rsp_type rsp_in;

   logic [WAYS-1:0][cslw_pkg::TAG_BITS-1:0] tag_ff;
   logic [WAYS-1:0][cslw_pkg::TAG_BITS-1:0] tag_in;
   logic [WAYS-1:0] valid_ff;
   logic [WAYS-1:0] valid_in;
   logic [WAYS-1:0] dirty_ff;
   logic [WAYS-1:0] dirty_in;
   logic [WAYS-1:0][RANK_W-1:0] rank_ff;
   logic [WAYS-1:0][RANK_W-1:0] rank_in;

   logic advance;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   cslw_lookup #(
      .WAYS(WAYS),
      .RANK_W(RANK_W)
   ) u_lookup (
      .req(in_req_ff),
      .way_tag(tag_ff),
      .way_valid(valid_ff),
      .way_dirty(dirty_ff),
      .way_rank(rank_ff),
      .tag_next(tag_in),
      .valid_next(valid_in),
      .dirty_next(dirty_in),
      .rank_next(rank_in),
      .rsp(rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tag_ff <= '0;
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int k = 0; k < WAYS; k++) begin
            rank_ff[k] <= RANK_W'(k);
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            tag_ff <= tag_in;
            valid_ff <= valid_in;
            dirty_ff <= dirty_in;
            rank_ff <= rank_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== src/cslw_checker.sv =====
// Port-level assertions for the cache set block and their bind.
`timescale 1ns / 1ps
`include "cache_set_lru_writeback_top_defines.svh"

module cslw_checker #(
   parameter int WAYS = cslw_pkg::WAYS_DEFAULT
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input cslw_pkg::req_type  req_payload,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input cslw_pkg::rsp_type  rsp_payload
);

   `CSLW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled result changed")
   `CSLW_ASSERT(a_outcome_code, clock, reset, rsp_valid |-> rsp_payload.outcome != cslw_pkg::OUTCOME_UNUSED, "unused outcome code")
   `CSLW_ASSERT(a_dirty_bound, clock, reset, rsp_valid |-> (WAYS > 7) || (int'(rsp_payload.dirty_count) <= WAYS), "dirty count above way count")
   `CSLW_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result present after reset")

endmodule

bind cache_set_lru_writeback_top cslw_checker #(.WAYS(WAYS)) u_checker (.*);
